@@ rtl/nbg_pkg.sv @@
// shared types, constants and helper functions of the n-body step block
package nbg_pkg;

    localparam int MAX_BODIES = 64;
    localparam int IDX_W      = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // arithmetic widths
    localparam int ACC_W   = 48;
    localparam int F_W     = 39;
    localparam int U_W     = 23;
    localparam int DVD_W   = 78;
    localparam int DEN_W   = 63;
    localparam int STEP_W  = 7;

    localparam logic [31:0]      GRAV_RESET = 32'd429497;
    localparam logic [F_W-1:0]   ACC_MAX    = '1;
    localparam logic [STEP_W-1:0] PULL_STEPS = 7'd78;
    localparam logic [STEP_W-1:0] DIR_STEPS  = 7'd54;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_STEP   = 2'd1,
        ACT_READ   = 2'd2,
        ACT_CLEAR  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic [31:0]        mass;
        logic               affected;
        logic               attracts;
    } body_t;

    // saturate a wide signed sum to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [48:0] hi;
        logic signed [48:0] lo;
        hi = 49'sd2147483647;
        lo = -49'sd2147483648;
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // magnitude of (a - b) / 2, truncated toward zero
    function automatic logic [31:0] half_diff_mag(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = {a[31], a} - {b[31], b};
        m = d[32] ? 33'(-d) : 33'(d);
        return m[32:1];
    endfunction

    // magnitude of the accumulator after clamping to the acceleration limit
    function automatic logic [F_W-1:0] clamp_mag(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-1:0] m;
        m = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        if (m > ACC_W'(ACC_MAX))
            return ACC_MAX;
        else
            return m[F_W-1:0];
    endfunction

endpackage

@@ rtl/nbody_gravity_euler_step.sv @@
// n-body table with direct-sum gravity and semi-implicit euler step
// append, clear: result strobe in the cycle after start; read: result after S_RD_WAIT; one item at a time
// step: each affected body is loaded, run over every slot and written back, an unaffected one is only
// loaded; a slot is skipped (self too) or coincident, or if attracting runs the pull and two direction divisions
// busy stays high through a step of a non-empty table and the result strobe follows the last body
// results cannot be stalled; reset empties the table and loads the default G
module nbody_gravity_euler_step
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic [31:0]        mass,
    input  logic               affected,
    input  logic               attracts,
    input  logic [23:0]        time_step,
    input  logic [5:0]         body_index,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_wdata,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic [31:0]        out_mass,
    output logic [6:0]         body_total
);

    localparam int CW = nbg_pkg::CNT_W;
    localparam int IW = nbg_pkg::IDX_W;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_LD_I, S_LD_WAIT, S_J_RD, S_J_WAIT,
        S_SQ_X, S_SQ_Y, S_NUM, S_R2, S_GO, S_PULL, S_UX_GO, S_UX,
        S_UY_GO, S_UY, S_TERM_X, S_TERM_Y, S_U_VX, S_U_VY, S_U_PX,
        S_U_PY, S_WB
    } state_t;

    state_t                     state_reg;
    logic [CW-1:0]              count_reg;
    logic [CW-1:0]              i_reg;
    logic [CW-1:0]              j_reg;
    logic [31:0]                grav_reg;
    logic                       done_reg;
    nbg_pkg::status_t           status_reg;
    logic signed [31:0]         opx_reg;
    logic signed [31:0]         opy_reg;
    logic signed [31:0]         ovx_reg;
    logic signed [31:0]         ovy_reg;
    logic [31:0]                om_reg;

    logic [23:0]                dt_reg;
    nbg_pkg::body_t             bi_reg;
    logic signed [nbg_pkg::ACC_W-1:0] accx_reg;
    logic signed [nbg_pkg::ACC_W-1:0] accy_reg;
    logic [31:0]                mdx_reg;
    logic [31:0]                mdy_reg;
    logic                       sdx_reg;
    logic                       sdy_reg;
    logic [31:0]                mj_reg;
    logic [63:0]                sqx_reg;
    logic [63:0]                sqy_reg;
    logic [63:0]                num_reg;
    logic [nbg_pkg::DEN_W-1:0]  r2_reg;
    logic [nbg_pkg::F_W-1:0]    f_reg;
    logic [nbg_pkg::U_W-1:0]    ux_reg;
    logic [nbg_pkg::U_W-1:0]    uy_reg;
    logic signed [31:0]         vx_reg;
    logic signed [31:0]         vy_reg;
    logic signed [31:0]         px_reg;

    logic                       accept;
    logic                       mem_we;
    logic [IW-1:0]              mem_waddr;
    nbg_pkg::body_t             mem_wdata;
    logic [IW-1:0]              mem_raddr;
    nbg_pkg::body_t             mem_rdata;

    logic                       div_start;
    logic [nbg_pkg::DVD_W-1:0]  div_dvd;
    logic [nbg_pkg::DEN_W-1:0]  div_den;
    logic [nbg_pkg::STEP_W-1:0] div_steps;
    logic                       div_busy;
    logic [nbg_pkg::DVD_W-1:0]  div_q;
    logic                       sqrt_start;
    logic                       sqrt_busy;
    logic [31:0]                root;

    logic [31:0]                m1_a;
    logic [31:0]                m1_b;
    logic [63:0]                m1_p;
    logic [39:0]                m2_a;
    logic [23:0]                m2_b;
    logic [63:0]                m2_p;
    logic                       m2_neg;
    logic [nbg_pkg::ACC_W-1:0]  term_mag;
    logic signed [nbg_pkg::ACC_W-1:0] term_s;
    logic signed [nbg_pkg::ACC_W-1:0] upd_s;
    logic signed [48:0]         upd_sum;
    logic signed [31:0]         upd_base;
    logic signed [31:0]         upd_res;
    logic                       in_range;
    logic                       last_i;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;

    // table
    nbg_table u_table
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared divider and square root
    nbg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_den),
        .steps    (div_steps),
        .busy     (div_busy),
        .quot     (div_q)
    );

    nbg_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (r2_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    assign in_range = 32'(body_index) < 32'(count_reg);
    assign last_i   = (i_reg + 1'b1) == count_reg;

    // memory port control
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = count_reg[IW-1:0];
        mem_wdata = {pos_x, pos_y, vel_x, vel_y, mass, affected, attracts};
        mem_raddr = IW'(body_index);
        case (state_reg)
            S_IDLE:
            begin
                mem_we = accept && action == nbg_pkg::ACT_APPEND
                         && 32'(count_reg) < nbg_pkg::MAX_BODIES;
            end
            S_LD_I:
            begin
                mem_raddr = i_reg[IW-1:0];
            end
            S_J_RD:
            begin
                mem_raddr = j_reg[IW-1:0];
            end
            S_WB:
            begin
                mem_we          = 1'b1;
                mem_waddr       = i_reg[IW-1:0];
                mem_wdata       = bi_reg;
                mem_wdata.pos_x = px_reg;
                mem_wdata.pos_y = upd_res;
                mem_wdata.vel_x = vx_reg;
                mem_wdata.vel_y = vy_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // divider and root launch
    always_comb
    begin
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        div_dvd    = {num_reg, 14'b0};
        div_den    = r2_reg;
        div_steps  = nbg_pkg::PULL_STEPS;
        case (state_reg)
            S_GO:
            begin
                div_start  = 1'b1;
                sqrt_start = 1'b1;
            end
            S_UX_GO:
            begin
                div_start = 1'b1;
                div_dvd   = {mdx_reg, 46'b0};
                div_den   = {31'b0, root};
                div_steps = nbg_pkg::DIR_STEPS;
            end
            S_UY_GO:
            begin
                div_start = 1'b1;
                div_dvd   = {mdy_reg, 46'b0};
                div_den   = {31'b0, root};
                div_steps = nbg_pkg::DIR_STEPS;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // square and gravity multiplier
    always_comb
    begin
        m1_a = grav_reg;
        m1_b = mj_reg;
        case (state_reg)
            S_SQ_X:
            begin
                m1_a = mdx_reg;
                m1_b = mdx_reg;
            end
            S_SQ_Y:
            begin
                m1_a = mdy_reg;
                m1_b = mdy_reg;
            end
            default:
            begin
                m1_a = grav_reg;
            end
        endcase
        m1_p = 64'(m1_a) * 64'(m1_b);
    end

    // pull and update multiplier
    always_comb
    begin
        m2_a     = {1'b0, f_reg};
        m2_b     = {1'b0, ux_reg};
        m2_neg   = sdx_reg;
        upd_base = bi_reg.vel_x;
        case (state_reg)
            S_TERM_Y:
            begin
                m2_b   = {1'b0, uy_reg};
                m2_neg = sdy_reg;
            end
            S_U_VX:
            begin
                m2_a   = {1'b0, nbg_pkg::clamp_mag(accx_reg)};
                m2_b   = dt_reg;
                m2_neg = accx_reg[nbg_pkg::ACC_W-1];
            end
            S_U_VY:
            begin
                m2_a     = {1'b0, nbg_pkg::clamp_mag(accy_reg)};
                m2_b     = dt_reg;
                m2_neg   = accy_reg[nbg_pkg::ACC_W-1];
                upd_base = bi_reg.vel_y;
            end
            S_U_PX:
            begin
                m2_a     = vx_reg[31] ? 40'(-41'(vx_reg)) : 40'(vx_reg);
                m2_b     = dt_reg;
                m2_neg   = vx_reg[31];
                upd_base = bi_reg.pos_x;
            end
            S_U_PY, S_WB:
            begin
                m2_a     = vy_reg[31] ? 40'(-41'(vy_reg)) : 40'(vy_reg);
                m2_b     = dt_reg;
                m2_neg   = vy_reg[31];
                upd_base = bi_reg.pos_y;
            end
            default:
            begin
                m2_neg = sdx_reg;
            end
        endcase
        m2_p     = 64'(m2_a) * 64'(m2_b);
        term_mag = nbg_pkg::ACC_W'(m2_p[63:22]);
        term_s   = m2_neg ? -$signed(term_mag) : $signed(term_mag);
        upd_s    = m2_neg ? -$signed(m2_p[63:16]) : $signed(m2_p[63:16]);
        upd_sum  = 49'(upd_base) + 49'(upd_s);
        upd_res  = nbg_pkg::sat32(upd_sum);
    end

    // sequencer, control state and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            grav_reg   <= nbg_pkg::GRAV_RESET;
            done_reg   <= 1'b0;
            status_reg <= nbg_pkg::ST_OK;
            opx_reg    <= '0;
            opy_reg    <= '0;
            ovx_reg    <= '0;
            ovy_reg    <= '0;
            om_reg     <= '0;
            dt_reg     <= '0;
            bi_reg     <= '0;
            accx_reg   <= '0;
            accy_reg   <= '0;
            mdx_reg    <= '0;
            mdy_reg    <= '0;
            sdx_reg    <= 1'b0;
            sdy_reg    <= 1'b0;
            mj_reg     <= '0;
            sqx_reg    <= '0;
            sqy_reg    <= '0;
            num_reg    <= '0;
            r2_reg     <= '0;
            f_reg      <= '0;
            ux_reg     <= '0;
            uy_reg     <= '0;
            vx_reg     <= '0;
            vy_reg     <= '0;
            px_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                grav_reg <= cfg_wdata;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= nbg_pkg::ST_OK;
                        opx_reg    <= '0;
                        opy_reg    <= '0;
                        ovx_reg    <= '0;
                        ovy_reg    <= '0;
                        om_reg     <= '0;
                        dt_reg     <= time_step;
                        i_reg      <= '0;
                        case (action)
                            nbg_pkg::ACT_APPEND:
                            begin
                                done_reg <= 1'b1;
                                if (32'(count_reg) < nbg_pkg::MAX_BODIES)
                                    count_reg <= count_reg + 1'b1;
                                else
                                    status_reg <= nbg_pkg::ST_FULL;
                            end
                            nbg_pkg::ACT_STEP:
                            begin
                                if (count_reg == '0)
                                    done_reg <= 1'b1;
                                else
                                    state_reg <= S_LD_I;
                            end
                            nbg_pkg::ACT_READ:
                            begin
                                if (in_range)
                                begin
                                    state_reg <= S_RD_WAIT;
                                end
                                else
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= nbg_pkg::ST_RANGE;
                                end
                            end
                            default:
                            begin
                                done_reg  <= 1'b1;
                                count_reg <= '0;
                            end
                        endcase
                    end
                end
                S_RD_WAIT:
                begin
                    opx_reg   <= mem_rdata.pos_x;
                    opy_reg   <= mem_rdata.pos_y;
                    ovx_reg   <= mem_rdata.vel_x;
                    ovy_reg   <= mem_rdata.vel_y;
                    om_reg    <= mem_rdata.mass;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_LD_I:
                begin
                    state_reg <= S_LD_WAIT;
                end
                S_LD_WAIT:
                begin
                    bi_reg   <= mem_rdata;
                    j_reg    <= '0;
                    accx_reg <= '0;
                    accy_reg <= '0;
                    if (mem_rdata.affected)
                    begin
                        state_reg <= S_J_RD;
                    end
                    else if (last_i)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_LD_I;
                    end
                end
                S_J_RD:
                begin
                    if (j_reg == count_reg)
                        state_reg <= S_U_VX;
                    else
                        state_reg <= S_J_WAIT;
                end
                S_J_WAIT:
                begin
                    mdx_reg <= nbg_pkg::half_diff_mag(mem_rdata.pos_x, bi_reg.pos_x);
                    mdy_reg <= nbg_pkg::half_diff_mag(mem_rdata.pos_y, bi_reg.pos_y);
                    sdx_reg <= mem_rdata.pos_x < bi_reg.pos_x;
                    sdy_reg <= mem_rdata.pos_y < bi_reg.pos_y;
                    mj_reg  <= mem_rdata.mass;
                    if (j_reg == i_reg || !mem_rdata.attracts)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_J_RD;
                    end
                    else
                    begin
                        state_reg <= S_SQ_X;
                    end
                end
                S_SQ_X:
                begin
                    sqx_reg   <= m1_p;
                    state_reg <= S_SQ_Y;
                end
                S_SQ_Y:
                begin
                    sqy_reg   <= m1_p;
                    state_reg <= S_NUM;
                end
                S_NUM:
                begin
                    num_reg   <= m1_p;
                    state_reg <= S_R2;
                end
                S_R2:
                begin
                    r2_reg <= nbg_pkg::DEN_W'(sqx_reg + sqy_reg);
                    if ((sqx_reg | sqy_reg) == '0)
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_J_RD;
                    end
                    else
                    begin
                        state_reg <= S_GO;
                    end
                end
                S_GO:
                begin
                    state_reg <= S_PULL;
                end
                S_PULL:
                begin
                    if (!div_busy && !sqrt_busy)
                    begin
                        f_reg <= (div_q[nbg_pkg::DVD_W-1:nbg_pkg::F_W] != '0)
                                 ? nbg_pkg::ACC_MAX : div_q[nbg_pkg::F_W-1:0];
                        state_reg <= S_UX_GO;
                    end
                end
                S_UX_GO:
                begin
                    state_reg <= S_UX;
                end
                S_UX:
                begin
                    if (!div_busy)
                    begin
                        ux_reg    <= div_q[nbg_pkg::U_W-1:0];
                        state_reg <= S_UY_GO;
                    end
                end
                S_UY_GO:
                begin
                    state_reg <= S_UY;
                end
                S_UY:
                begin
                    if (!div_busy)
                    begin
                        uy_reg    <= div_q[nbg_pkg::U_W-1:0];
                        state_reg <= S_TERM_X;
                    end
                end
                S_TERM_X:
                begin
                    accx_reg  <= accx_reg + term_s;
                    state_reg <= S_TERM_Y;
                end
                S_TERM_Y:
                begin
                    accy_reg  <= accy_reg + term_s;
                    j_reg     <= j_reg + 1'b1;
                    state_reg <= S_J_RD;
                end
                S_U_VX:
                begin
                    vx_reg    <= upd_res;
                    state_reg <= S_U_VY;
                end
                S_U_VY:
                begin
                    vy_reg    <= upd_res;
                    state_reg <= S_U_PX;
                end
                S_U_PX:
                begin
                    px_reg    <= upd_res;
                    state_reg <= S_U_PY;
                end
                S_U_PY:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (last_i)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_LD_I;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign done       = done_reg;
    assign status     = status_reg;
    assign out_pos_x  = opx_reg;
    assign out_pos_y  = opy_reg;
    assign out_vel_x  = ovx_reg;
    assign out_vel_y  = ovy_reg;
    assign out_mass   = om_reg;
    assign body_total = 7'(count_reg);

endmodule

@@ rtl/nbg_table.sv @@
// body table memory, one write port and one registered read port
module nbg_table
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [nbg_pkg::IDX_W-1:0] waddr,
    input  nbg_pkg::body_t           wdata,
    input  logic [nbg_pkg::IDX_W-1:0] raddr,
    output nbg_pkg::body_t           rdata
);

    nbg_pkg::body_t mem [nbg_pkg::MAX_BODIES];

    // write and registered read, a read of the written address returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/nbg_div.sv @@
// restoring divider, one quotient bit per cycle
module nbg_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nbg_pkg::DVD_W-1:0] dividend,
    input  logic [nbg_pkg::DEN_W-1:0] divisor,
    input  logic [nbg_pkg::STEP_W-1:0] steps,
    output logic                      busy,
    output logic [nbg_pkg::DVD_W-1:0] quot
);

    logic [nbg_pkg::STEP_W-1:0] cnt_reg;
    logic [nbg_pkg::DVD_W-1:0]  dvd_reg;
    logic [nbg_pkg::DEN_W-1:0]  den_reg;
    logic [nbg_pkg::DEN_W-1:0]  rem_reg;
    logic [nbg_pkg::DVD_W-1:0]  quot_reg;

    logic [nbg_pkg::DEN_W:0]    shifted;
    logic [nbg_pkg::DEN_W:0]    diff;
    logic                       ge;

    // trial subtract of the shifted remainder
    always_comb
    begin
        shifted = {rem_reg, dvd_reg[nbg_pkg::DVD_W-1]};
        diff    = shifted - {1'b0, den_reg};
        ge      = shifted >= {1'b0, den_reg};
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= steps;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg  <= dividend;
            den_reg  <= divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg  <= {dvd_reg[nbg_pkg::DVD_W-2:0], 1'b0};
            rem_reg  <= ge ? diff[nbg_pkg::DEN_W-1:0] : shifted[nbg_pkg::DEN_W-1:0];
            quot_reg <= {quot_reg[nbg_pkg::DVD_W-2:0], ge};
        end
    end

    assign busy = cnt_reg != '0;
    assign quot = quot_reg;

endmodule

@@ rtl/nbg_sqrt.sv @@
// integer square root, one result bit per cycle
module nbg_sqrt
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nbg_pkg::DEN_W-1:0] radicand,
    output logic                      busy,
    output logic [31:0]               root
);

    logic [nbg_pkg::DEN_W-1:0] b_reg;
    logic [nbg_pkg::DEN_W-1:0] x_reg;
    logic [63:0]               r_reg;
    logic [63:0]               rb;
    logic                      take;

    // trial subtract
    always_comb
    begin
        rb   = r_reg + {1'b0, b_reg};
        take = {1'b0, x_reg} >= rb;
    end

    // bit marker, walks down two places per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else if (start)
        begin
            b_reg <= {1'b1, {(nbg_pkg::DEN_W-1){1'b0}}};
        end
        else
        begin
            b_reg <= b_reg >> 2;
        end
    end

    // remainder and root
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= radicand;
            r_reg <= '0;
        end
        else if (b_reg != '0)
        begin
            if (take)
            begin
                x_reg <= x_reg - rb[nbg_pkg::DEN_W-1:0];
                r_reg <= (r_reg >> 1) + {1'b0, b_reg};
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
        end
    end

    assign busy = b_reg != '0;
    assign root = r_reg[31:0];

endmodule

@@ rtl/nbg_checker.sv @@
// port-level checks of the n-body step block, bound to the top level
module nbg_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         action,
    input logic               done,
    input logic [1:0]         status,
    input logic signed [31:0] out_pos_x,
    input logic signed [31:0] out_pos_y,
    input logic signed [31:0] out_vel_x,
    input logic signed [31:0] out_vel_y,
    input logic [31:0]        out_mass,
    input logic [6:0]         body_total
);

    // append, read and clear raise busy or done once the item is taken
    a_quick: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action != nbg_pkg::ACT_STEP |=> done || busy)
        else $error("short item gave no result");

    // a step either finishes at once or holds busy
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == nbg_pkg::ACT_STEP |=> busy || done)
        else $error("step neither busy nor done");

    // errors carry zero body fields
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != nbg_pkg::ST_OK |->
        out_pos_x == 0 && out_pos_y == 0 && out_vel_x == 0 && out_vel_y == 0
        && out_mass == 0)
        else $error("error result with body data");

    // clear empties the table
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action == nbg_pkg::ACT_CLEAR |=> done && body_total == 0)
        else $error("clear left bodies");

    // full only when the table is at capacity
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == nbg_pkg::ST_FULL |-> body_total == 7'(nbg_pkg::MAX_BODIES))
        else $error("full reported below capacity");

endmodule

bind nbody_gravity_euler_step nbg_checker u_nbg_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .done       (done),
    .status     (status),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_vel_x  (out_vel_x),
    .out_vel_y  (out_vel_y),
    .out_mass   (out_mass),
    .body_total (body_total)
);

@@ bench/testbench.sv @@
// testbench for the n-body gravity step block: table stimulus, random items, predictor check
`timescale 1ns / 100ps

module testbench;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 12;
    localparam longint ACC_LIM    = 64'sd549755813887;

    typedef struct {
        nbg_pkg::action_t   act;
        logic signed [31:0] px, py, vx, vy;
        logic [31:0]        m;
        logic               aff, att;
        logic [23:0]        dt;
        logic [5:0]         idx;
    } item_t;

    typedef struct {
        nbg_pkg::status_t   st;
        logic signed [31:0] px, py, vx, vy;
        logic [31:0]        m;
        logic [6:0]         total;
    } reply_t;

    typedef struct {
        item_t  it;
        bit     fixed;
        reply_t rep;
    } row_t;

    logic               clk, rst_n, start, busy, done;
    logic [1:0]         action;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [31:0]        mass;
    logic               affected, attracts;
    logic [23:0]        time_step;
    logic [5:0]         body_index;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic [1:0]         status;
    logic signed [31:0] out_pos_x, out_pos_y, out_vel_x, out_vel_y;
    logic [31:0]        out_mass;
    logic [6:0]         body_total;

    nbody_gravity_euler_step dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .action(action),
        .pos_x(pos_x), .pos_y(pos_y), .vel_x(vel_x), .vel_y(vel_y), .mass(mass),
        .affected(affected), .attracts(attracts), .time_step(time_step),
        .body_index(body_index), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .done(done), .status(status), .out_pos_x(out_pos_x), .out_pos_y(out_pos_y),
        .out_vel_x(out_vel_x), .out_vel_y(out_vel_y), .out_mass(out_mass),
        .body_total(body_total)
    );

    // predictor state
    logic signed [31:0] t_px [nbg_pkg::MAX_BODIES];
    logic signed [31:0] t_py [nbg_pkg::MAX_BODIES];
    logic signed [31:0] t_vx [nbg_pkg::MAX_BODIES];
    logic signed [31:0] t_vy [nbg_pkg::MAX_BODIES];
    logic [31:0]        t_m  [nbg_pkg::MAX_BODIES];
    logic               t_aff[nbg_pkg::MAX_BODIES];
    logic               t_att[nbg_pkg::MAX_BODIES];
    int                 n_bodies;
    logic [31:0]        grav;

    reply_t pending[$];
    row_t   rows[$];
    int     errors;
    int     quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic longint sat_q16(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // signed product shifted down, truncated toward zero
    function automatic longint mul_trunc(longint a, longint b, int sh);
        logic [63:0] ma, mb, p;
        ma = (a < 0) ? 64'(-a) : 64'(a);
        mb = (b < 0) ? 64'(-b) : 64'(b);
        p = (ma * mb) >> sh;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // one semi-implicit euler step, bodies updated in slot order
    task automatic gravity_step(logic [23:0] dt);
        longint ax, ay, dx, dy, ux, uy, nvx, nvy;
        logic [63:0] mdx, mdy, r2, r;
        logic [127:0] q;
        for (int i = 0; i < n_bodies; i++)
        begin
            if (!t_aff[i]) continue;
            ax = 0;
            ay = 0;
            for (int j = 0; j < n_bodies; j++)
            begin
                if (j == i || !t_att[j]) continue;
                dx = (longint'(t_px[j]) - longint'(t_px[i])) / 2;
                dy = (longint'(t_py[j]) - longint'(t_py[i])) / 2;
                mdx = (dx < 0) ? 64'(-dx) : 64'(dx);
                mdy = (dy < 0) ? 64'(-dy) : 64'(dy);
                r2 = mdx * mdx + mdy * mdy;
                if (r2 == 0) continue;
                r = root_floor(r2);
                q = (128'(64'(grav) * 64'(t_m[j])) << 14) / 128'(r2);
                if (q > 128'(ACC_LIM)) q = 128'(ACC_LIM);
                ux = longint'((mdx << 22) / r);
                uy = longint'((mdy << 22) / r);
                if (dx < 0) ux = -ux;
                if (dy < 0) uy = -uy;
                ax += mul_trunc(longint'(q[63:0]), ux, 22);
                ay += mul_trunc(longint'(q[63:0]), uy, 22);
            end
            ax = (ax > ACC_LIM) ? ACC_LIM : (ax < -ACC_LIM) ? -ACC_LIM : ax;
            ay = (ay > ACC_LIM) ? ACC_LIM : (ay < -ACC_LIM) ? -ACC_LIM : ay;
            nvx = sat_q16(longint'(t_vx[i]) + mul_trunc(ax, longint'(dt), 16));
            nvy = sat_q16(longint'(t_vy[i]) + mul_trunc(ay, longint'(dt), 16));
            t_vx[i] = nvx[31:0];
            t_vy[i] = nvy[31:0];
            t_px[i] = 32'(sat_q16(longint'(t_px[i]) + mul_trunc(nvx, longint'(dt), 16)));
            t_py[i] = 32'(sat_q16(longint'(t_py[i]) + mul_trunc(nvy, longint'(dt), 16)));
        end
    endtask

    // expected reply of one item, and the table update it causes
    task automatic apply_item(item_t it, output reply_t rep);
        rep = '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0};
        case (it.act)
            nbg_pkg::ACT_APPEND:
            begin
                if (n_bodies < nbg_pkg::MAX_BODIES)
                begin
                    t_px[n_bodies]  = it.px;
                    t_py[n_bodies]  = it.py;
                    t_vx[n_bodies]  = it.vx;
                    t_vy[n_bodies]  = it.vy;
                    t_m[n_bodies]   = it.m;
                    t_aff[n_bodies] = it.aff;
                    t_att[n_bodies] = it.att;
                    n_bodies++;
                end
                else
                    rep.st = nbg_pkg::ST_FULL;
            end
            nbg_pkg::ACT_STEP:
                gravity_step(it.dt);
            nbg_pkg::ACT_READ:
            begin
                if (int'(it.idx) < n_bodies)
                begin
                    rep.px = t_px[it.idx];
                    rep.py = t_py[it.idx];
                    rep.vx = t_vx[it.idx];
                    rep.vy = t_vy[it.idx];
                    rep.m  = t_m[it.idx];
                end
                else
                    rep.st = nbg_pkg::ST_RANGE;
            end
            default:
                n_bodies = 0;
        endcase
        rep.total = 7'(n_bodies);
    endtask

    // present an item and hold it until the block takes it
    task automatic issue(item_t it, bit fixed, reply_t typed);
        reply_t rep;
        start      <= 1'b1;
        action     <= it.act;
        pos_x      <= it.px;
        pos_y      <= it.py;
        vel_x      <= it.vx;
        vel_y      <= it.vy;
        mass       <= it.m;
        affected   <= it.aff;
        attracts   <= it.att;
        time_step  <= it.dt;
        body_index <= it.idx;
        do @(posedge clk); while (busy);
        apply_item(it, rep);
        pending = {pending, (fixed ? typed : rep)};
    endtask

    task automatic sender_gap(int pct);
        if ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_grav(logic [31:0] g);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge clk);
        cfg_we    <= 1'b0;
        grav = g;
    endtask

    function automatic item_t blank(nbg_pkg::action_t a);
        item_t it;
        it = '{a, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 0};
        return it;
    endfunction

    function automatic item_t body(logic signed [31:0] px, logic signed [31:0] py,
                                   logic signed [31:0] vx, logic signed [31:0] vy,
                                   logic [31:0] m, logic aff, logic att);
        item_t it;
        it = '{nbg_pkg::ACT_APPEND, px, py, vx, vy, m, aff, att, 0, 0};
        return it;
    endfunction

    // append one row to the directed table
    task automatic add_row(item_t it, bit fixed, reply_t rep);
        row_t r;
        r.it = it;
        r.fixed = fixed;
        r.rep = rep;
        rows = {rows, r};
    endtask

    // random item, mostly well-formed with a small table so steps stay short
    function automatic item_t random_item();
        item_t it;
        int    r;
        it = blank(nbg_pkg::ACT_READ);
        it.px = $urandom;
        it.py = $urandom;
        it.vx = $urandom;
        it.vy = $urandom;
        it.m  = $urandom;
        it.aff = 1'($urandom_range(1));
        it.att = 1'($urandom_range(1));
        it.dt = 24'($urandom_range(24'hffffff));
        it.idx = 6'($urandom_range(63));
        r = $urandom_range(99);
        if (r < 40 || n_bodies == 0)
        begin
            it.act = nbg_pkg::ACT_APPEND;
            if ($urandom_range(3) != 0)
            begin
                it.px = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
                it.py = $signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000;
                it.vx = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
                it.vy = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
                it.aff = ($urandom_range(4) != 0);
                it.att = ($urandom_range(4) != 0);
            end
            if (n_bodies >= 10) it.act = nbg_pkg::ACT_CLEAR;
        end
        else if (r < 65)
        begin
            it.act = nbg_pkg::ACT_STEP;
            if ($urandom_range(3) != 0) it.dt = 24'($urandom_range(24'h1_0000));
        end
        else if (r < 95)
        begin
            if ($urandom_range(4) != 0) it.idx = 6'($urandom_range(n_bodies - 1));
        end
        else
            it.act = nbg_pkg::ACT_CLEAR;
        return it;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && done)
        begin
            if (pending.size() == 0)
            begin
                $display("%0t: result with nothing expected", $time);
                errors++;
            end
            else
            begin
                want = pending.pop_front();
                if (status != want.st)
                begin
                    $display("%0t: status exp %0d got %0d", $time, want.st, status);
                    errors++;
                end
                if (out_pos_x != want.px)
                begin
                    $display("%0t: pos_x exp %h got %h", $time, want.px, out_pos_x);
                    errors++;
                end
                if (out_pos_y != want.py)
                begin
                    $display("%0t: pos_y exp %h got %h", $time, want.py, out_pos_y);
                    errors++;
                end
                if (out_vel_x != want.vx)
                begin
                    $display("%0t: vel_x exp %h got %h", $time, want.vx, out_vel_x);
                    errors++;
                end
                if (out_vel_y != want.vy)
                begin
                    $display("%0t: vel_y exp %h got %h", $time, want.vy, out_vel_y);
                    errors++;
                end
                if (out_mass != want.m)
                begin
                    $display("%0t: mass exp %h got %h", $time, want.m, out_mass);
                    errors++;
                end
                if (body_total != want.total)
                begin
                    $display("%0t: total exp %0d got %0d", $time, want.total, body_total);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no item taken and no result
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        reply_t none;
        item_t  it;
        int     idle_pct[4];
        logic [31:0] grav_set[4];

        errors = 0;
        quiet_cycles = 0;
        n_bodies = 0;
        grav = nbg_pkg::GRAV_RESET;
        start = 1'b0;
        action = nbg_pkg::ACT_APPEND;
        pos_x = 0;
        pos_y = 0;
        vel_x = 0;
        vel_y = 0;
        mass = 0;
        affected = 1'b0;
        attracts = 1'b0;
        time_step = 0;
        body_index = 0;
        cfg_we = 1'b0;
        cfg_wdata = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        none = '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0};

        // directed table
        it = blank(nbg_pkg::ACT_READ);
        add_row(it, 1, '{nbg_pkg::ST_RANGE, 0, 0, 0, 0, 0, 0});
        it = blank(nbg_pkg::ACT_STEP);
        it.dt = 24'hffffff;
        add_row(it, 1, '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0});
        add_row(body(32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                     32'sh7fffffff, 32'hffffffff, 1, 1), 1,
                '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 1});
        add_row(blank(nbg_pkg::ACT_READ), 1,
                '{nbg_pkg::ST_OK, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                  32'sh7fffffff, 32'hffffffff, 1});
        add_row(body(32'sh80000000, 32'sh7fffffff, 0, 0, 0, 1, 1), 1,
                '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 2});
        add_row(it, 0, none);
        it = blank(nbg_pkg::ACT_READ);
        add_row(it, 0, none);
        it.idx = 1;
        add_row(it, 0, none);
        it.idx = 2;
        add_row(it, 1, '{nbg_pkg::ST_RANGE, 0, 0, 0, 0, 0, 2});
        add_row(blank(nbg_pkg::ACT_CLEAR), 1, '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0});
        add_row(body(0, 0, 0, 0, 1000, 1, 1), 1, '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 1});
        // coincident pair: within one raw unit on both axes
        add_row(body(1, -1, 0, 0, 5000, 1, 1), 0, none);
        // not affected, then not attracting
        add_row(body(32'sh000a_0000, 0, 32'sh0001_0000, 0, 32'h0010_0000, 0, 1),
                0, none);
        add_row(body(0, 32'sh0005_0000, 0, 0, 32'h0100_0000, 1, 0), 0, none);
        it = blank(nbg_pkg::ACT_STEP);
        add_row(it, 0, none);
        it.dt = 24'h01_0000;
        add_row(it, 0, none);
        for (int k = 0; k < 4; k++)
        begin
            it = blank(nbg_pkg::ACT_READ);
            it.idx = 6'(k);
            add_row(it, 0, none);
        end
        it.idx = 63;
        add_row(it, 1, '{nbg_pkg::ST_RANGE, 0, 0, 0, 0, 0, 4});
        add_row(blank(nbg_pkg::ACT_CLEAR), 1, '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0});

        foreach (rows[k])
            issue(rows[k].it, rows[k].fixed, rows[k].rep);

        // full table, then the rejected append
        for (int k = 0; k < nbg_pkg::MAX_BODIES; k++)
            issue(body($urandom, $urandom, $urandom, $urandom, $urandom, 1, 1), 0, none);
        issue(body(5, 6, 7, 8, 9, 1, 1), 1, '{nbg_pkg::ST_FULL, 0, 0, 0, 0, 0, 64});
        it = blank(nbg_pkg::ACT_READ);
        it.idx = 63;
        issue(it, 0, none);
        issue(blank(nbg_pkg::ACT_CLEAR), 1, '{nbg_pkg::ST_OK, 0, 0, 0, 0, 0, 0});

        // random phases, each under its own G, with the sender idling set per phase
        idle_pct = '{0, 78, 0, 13};
        grav_set = '{32'd0, 32'hffffffff, $urandom, nbg_pkg::GRAV_RESET};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_grav(grav_set[ph]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                sender_gap(idle_pct[ph]);
                issue(random_item(), 0, none);
            end
        end

        wait_drained();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
